// ----- hdl/lweh_pkg.sv -----
// Shared types, constants and counter helpers for the letter and word-edge histogram.
`default_nettype none

package lweh_pkg;

	// Counter and alphabet geometry.
	localparam int COUNT_W     = 32;
	localparam int OUT_W       = 32;
	localparam int ALPHA_N     = 26;
	localparam int NUM_LETTERS = 2 * ALPHA_N;
	localparam int IDX_W       = $clog2(NUM_LETTERS);

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// ASCII letter bounds.
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

	// Input operation codes.
	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic             op;
		logic [7:0]       byte_value;
		logic [IDX_W-1:0] query_letter;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] freq_count;
		logic [OUT_W-1:0] begin_count;
		logic [OUT_W-1:0] end_count;
		logic [OUT_W-1:0] total_letters;
	} out_item_t;

	// Work handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_LETTER = 2'd0,
		CMD_END    = 2'd1,
		CMD_READ   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             first;     // letter opens a word
		logic             in_range;  // read index names a letter
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_push_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// Saturating increment of a counter.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		if (v == {COUNT_W{1'b1}})
			return v;
		return v + COUNT_W'(1);
	endfunction

	// Clamp a counter to the reported width.
	function automatic logic [OUT_W-1:0] report_count(input logic [COUNT_W-1:0] v);
		localparam int EXT_W = (COUNT_W > OUT_W) ? COUNT_W : OUT_W;
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		if (ext > EXT_W'({OUT_W{1'b1}}))
			return {OUT_W{1'b1}};
		return ext[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/lweh_front.sv -----
// Front end: accepts words, classifies bytes and tracks word boundaries.
`default_nettype none

module lweh_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  lweh_pkg::in_item_t     in_data,
	input  wire                    case_sensitive,
	input  wire                    q_full,
	output lweh_pkg::q_push_t      push
);

	logic                          in_word_q;
	logic [lweh_pkg::IDX_W-1:0]    last_letter_q;
	logic                          accept;
	logic                          is_lower;
	logic                          is_upper;
	logic                          is_letter;
	logic [lweh_pkg::IDX_W-1:0]    raw_idx;
	logic [lweh_pkg::IDX_W-1:0]    fold_cur;
	logic [lweh_pkg::IDX_W-1:0]    fold_last;
	logic                          q_ok;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Byte classification and case folding.
	always_comb begin
		is_lower  = (in_data.byte_value >= lweh_pkg::CHAR_LOWER_A) &&
		            (in_data.byte_value <= lweh_pkg::CHAR_LOWER_Z);
		is_upper  = (in_data.byte_value >= lweh_pkg::CHAR_UPPER_A) &&
		            (in_data.byte_value <= lweh_pkg::CHAR_UPPER_Z);
		is_letter = is_lower || is_upper;
		if (is_lower) begin
			raw_idx = lweh_pkg::IDX_W'(in_data.byte_value - lweh_pkg::CHAR_LOWER_A);
		end else begin
			raw_idx = lweh_pkg::IDX_W'(in_data.byte_value - lweh_pkg::CHAR_UPPER_A) +
			          lweh_pkg::IDX_W'(lweh_pkg::ALPHA_N);
		end
		fold_cur = raw_idx;
		if (!case_sensitive && raw_idx >= lweh_pkg::IDX_W'(lweh_pkg::ALPHA_N))
			fold_cur = raw_idx - lweh_pkg::IDX_W'(lweh_pkg::ALPHA_N);
		fold_last = last_letter_q;
		if (!case_sensitive && last_letter_q >= lweh_pkg::IDX_W'(lweh_pkg::ALPHA_N))
			fold_last = last_letter_q - lweh_pkg::IDX_W'(lweh_pkg::ALPHA_N);
		q_ok = in_data.query_letter < lweh_pkg::IDX_W'(lweh_pkg::NUM_LETTERS);
	end

	// Build the command for the back end; a non-letter outside a word makes none.
	always_comb begin
		push.valid        = 1'b0;
		push.cmd.kind     = lweh_pkg::CMD_READ;
		push.cmd.first    = 1'b0;
		push.cmd.in_range = 1'b1;
		push.cmd.idx      = '0;
		if (in_data.op == lweh_pkg::OP_READ) begin
			push.valid        = accept;
			push.cmd.kind     = lweh_pkg::CMD_READ;
			push.cmd.in_range = q_ok;
			push.cmd.idx      = q_ok ? in_data.query_letter : '0;
		end else if (is_letter) begin
			push.valid     = accept;
			push.cmd.kind  = lweh_pkg::CMD_LETTER;
			push.cmd.first = !in_word_q;
			push.cmd.idx   = fold_cur;
		end else if (in_word_q) begin
			push.valid    = accept;
			push.cmd.kind = lweh_pkg::CMD_END;
			push.cmd.idx  = fold_last;
		end
	end

	// Word state carries across the whole stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q     <= 1'b0;
			last_letter_q <= '0;
		end else if (accept && in_data.op == lweh_pkg::OP_COUNT) begin
			if (is_letter) begin
				in_word_q     <= 1'b1;
				last_letter_q <= raw_idx;
			end else begin
				in_word_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lweh_queue.sv -----
// Short command queue that decouples the front end from the counter back end.
`default_nettype none

module lweh_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lweh_pkg::q_push_t     push,
	input  wire                   pop,
	output logic                  full,
	output lweh_pkg::q_head_t     head
);

	lweh_pkg::cmd_t                     slot_q [lweh_pkg::QUEUE_DEPTH];
	logic [lweh_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [lweh_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [lweh_pkg::QUEUE_CNT_W-1:0]   count_q;

	assign full       = count_q == lweh_pkg::QUEUE_CNT_W'(lweh_pkg::QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.cmd   = slot_q[rd_ptr_q];

	function automatic logic [lweh_pkg::QUEUE_PTR_W-1:0] next_ptr(
		input logic [lweh_pkg::QUEUE_PTR_W-1:0] p);
		if (p == lweh_pkg::QUEUE_PTR_W'(lweh_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + lweh_pkg::QUEUE_PTR_W'(1);
	endfunction

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push.valid)
			slot_q[wr_ptr_q] <= push.cmd;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push.valid, pop})
				2'b10: count_q <= count_q + lweh_pkg::QUEUE_CNT_W'(1);
				2'b01: count_q <= count_q - lweh_pkg::QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("command pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("command popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lweh_pkg::QUEUE_CNT_W'(lweh_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// ----- hdl/lweh_back.sv -----
// Back end: counter memories with read-modify-write forwarding and the result register.
`default_nettype none

module lweh_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lweh_pkg::q_head_t     head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_stall,
	output lweh_pkg::out_item_t   out_data
);

	// Counter memories and their written-entry flags.
	logic [lweh_pkg::COUNT_W-1:0]     freq_mem [lweh_pkg::NUM_LETTERS];
	logic [lweh_pkg::COUNT_W-1:0]     beg_mem  [lweh_pkg::NUM_LETTERS];
	logic [lweh_pkg::COUNT_W-1:0]     end_mem  [lweh_pkg::NUM_LETTERS];
	logic [lweh_pkg::NUM_LETTERS-1:0] freq_vld_q;
	logic [lweh_pkg::NUM_LETTERS-1:0] beg_vld_q;
	logic [lweh_pkg::NUM_LETTERS-1:0] end_vld_q;

	// Update stage.
	logic                             vld_s1;
	lweh_pkg::cmd_t                   cmd_s1;
	logic [lweh_pkg::COUNT_W-1:0]     freq_raw_s1;
	logic [lweh_pkg::COUNT_W-1:0]     beg_raw_s1;
	logic [lweh_pkg::COUNT_W-1:0]     end_raw_s1;
	logic                             freq_ok_s1;
	logic                             beg_ok_s1;
	logic                             end_ok_s1;

	// Last write, for forwarding into the stage.
	logic                             fwd_freq_v_q;
	logic                             fwd_beg_v_q;
	logic                             fwd_end_v_q;
	logic [lweh_pkg::IDX_W-1:0]       fwd_idx_q;
	logic [lweh_pkg::COUNT_W-1:0]     fwd_freq_q;
	logic [lweh_pkg::COUNT_W-1:0]     fwd_beg_q;
	logic [lweh_pkg::COUNT_W-1:0]     fwd_end_q;

	logic [lweh_pkg::COUNT_W-1:0]     total_q;
	logic                             out_v_q;
	lweh_pkg::out_item_t              out_q;

	logic                             s1_done;
	logic                             adv;
	logic                             is_read;
	logic                             wr_freq;
	logic                             wr_beg;
	logic                             wr_end;
	logic [lweh_pkg::COUNT_W-1:0]     cur_freq;
	logic [lweh_pkg::COUNT_W-1:0]     cur_beg;
	logic [lweh_pkg::COUNT_W-1:0]     cur_end;
	logic [lweh_pkg::COUNT_W-1:0]     new_freq;
	logic [lweh_pkg::COUNT_W-1:0]     new_beg;
	logic [lweh_pkg::COUNT_W-1:0]     new_end;

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// Stage control: counter updates always retire, a read waits for the result register.
	always_comb begin
		is_read = cmd_s1.kind == lweh_pkg::CMD_READ;
		s1_done = vld_s1 && (!is_read || !out_v_q || !out_stall);
		adv     = !vld_s1 || s1_done;
		pop     = head.valid && adv;
	end

	// Current counter values, with the previous write forwarded over the stale read.
	always_comb begin
		cur_freq = freq_ok_s1 ? freq_raw_s1 : '0;
		cur_beg  = beg_ok_s1 ? beg_raw_s1 : '0;
		cur_end  = end_ok_s1 ? end_raw_s1 : '0;
		if (fwd_freq_v_q && fwd_idx_q == cmd_s1.idx)
			cur_freq = fwd_freq_q;
		if (fwd_beg_v_q && fwd_idx_q == cmd_s1.idx)
			cur_beg = fwd_beg_q;
		if (fwd_end_v_q && fwd_idx_q == cmd_s1.idx)
			cur_end = fwd_end_q;
		new_freq = lweh_pkg::sat_inc(cur_freq);
		new_beg  = lweh_pkg::sat_inc(cur_beg);
		new_end  = lweh_pkg::sat_inc(cur_end);
	end

	// Which counters the retiring command writes.
	always_comb begin
		wr_freq = 1'b0;
		wr_beg  = 1'b0;
		wr_end  = 1'b0;
		case (cmd_s1.kind)
			lweh_pkg::CMD_LETTER: begin
				wr_freq = s1_done;
				wr_beg  = s1_done && cmd_s1.first;
			end
			lweh_pkg::CMD_END: begin
				wr_end = s1_done;
			end
			default: begin
				wr_freq = 1'b0;
			end
		endcase
	end

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (wr_freq)
			freq_mem[cmd_s1.idx] <= new_freq;
		if (wr_beg)
			beg_mem[cmd_s1.idx] <= new_beg;
		if (wr_end)
			end_mem[cmd_s1.idx] <= new_end;
		if (pop) begin
			cmd_s1      <= head.cmd;
			freq_raw_s1 <= freq_mem[head.cmd.idx];
			beg_raw_s1  <= beg_mem[head.cmd.idx];
			end_raw_s1  <= end_mem[head.cmd.idx];
			freq_ok_s1  <= freq_vld_q[head.cmd.idx];
			beg_ok_s1   <= beg_vld_q[head.cmd.idx];
			end_ok_s1   <= end_vld_q[head.cmd.idx];
		end
		if (adv) begin
			fwd_idx_q  <= cmd_s1.idx;
			fwd_freq_q <= new_freq;
			fwd_beg_q  <= new_beg;
			fwd_end_q  <= new_end;
		end
		if (s1_done && is_read) begin
			out_q.freq_count    <= cmd_s1.in_range ? lweh_pkg::report_count(cur_freq) : '0;
			out_q.begin_count   <= cmd_s1.in_range ? lweh_pkg::report_count(cur_beg) : '0;
			out_q.end_count     <= cmd_s1.in_range ? lweh_pkg::report_count(cur_end) : '0;
			out_q.total_letters <= lweh_pkg::report_count(total_q);
		end
	end

	// Control state, entry flags and the running total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			fwd_freq_v_q <= 1'b0;
			fwd_beg_v_q  <= 1'b0;
			fwd_end_v_q  <= 1'b0;
			freq_vld_q   <= '0;
			beg_vld_q    <= '0;
			end_vld_q    <= '0;
			total_q      <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1       <= head.valid;
				fwd_freq_v_q <= wr_freq;
				fwd_beg_v_q  <= wr_beg;
				fwd_end_v_q  <= wr_end;
			end
			if (wr_freq) begin
				freq_vld_q[cmd_s1.idx] <= 1'b1;
				total_q                <= lweh_pkg::sat_inc(total_q);
			end
			if (wr_beg)
				beg_vld_q[cmd_s1.idx] <= 1'b1;
			if (wr_end)
				end_vld_q[cmd_s1.idx] <= 1'b1;
			if (s1_done && is_read)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	a_total_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("letter total went backwards");

endmodule

`default_nettype wire

// ----- hdl/letter_word_edge_histogram.sv -----
// A read word passes through the command queue, the update stage and the result register before it shows on out_valid.
// Throughput: one word per cycle on both sides while neither side stalls; counter updates retire one per cycle
// unless a read holds the stage, through read-modify-write with forwarding of the previous write.
// Input stalls only when the four-entry command queue is full.
// Reset clears all counters at once through per-entry written flags; no clearing pass.
// Folding mode resets to case-insensitive.
`default_nettype none

module letter_word_edge_histogram (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  lweh_pkg::in_item_t     in_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output lweh_pkg::out_item_t    out_data,
	input  wire                    cfg_wr_en,
	input  wire                    cfg_wr_data
);

	logic                case_sensitive_q;
	logic                q_full;
	logic                q_pop;
	lweh_pkg::q_push_t   q_push;
	lweh_pkg::q_head_t   q_head;

	// Case mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			case_sensitive_q <= 1'b0;
		else if (cfg_wr_en)
			case_sensitive_q <= cfg_wr_data;
	end

	lweh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.case_sensitive (case_sensitive_q),
		.q_full         (q_full),
		.push           (q_push)
	);

	lweh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.full   (q_full),
		.head   (q_head)
	);

	lweh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the letter and word-edge histogram: directed script, then random text.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lweh_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_WORDS  = 100;
	localparam int PHASE_COUNT  = 6;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// One line of the directed script; pinned rows carry a hand-computed read result.
	typedef struct {
		in_item_t  item;
		bit        pinned;
		out_item_t want;
	} script_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_wr_en = 1'b0;
	logic      cfg_wr_data = 1'b0;

	// Hand-computed result that travels with the word on the input.
	bit        word_pinned = 1'b0;
	out_item_t word_want = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;

	// Predicted histogram state.
	logic [COUNT_W-1:0] occur_cnt  [NUM_LETTERS];
	logic [COUNT_W-1:0] start_cnt  [NUM_LETTERS];
	logic [COUNT_W-1:0] finish_cnt [NUM_LETTERS];
	logic [COUNT_W-1:0] letters_seen;
	logic               word_open;
	logic [IDX_W-1:0]   prev_letter;
	logic               case_kept;

	// Read results still owed by the block, oldest first.
	out_item_t read_results_due[$];

	letter_word_edge_histogram u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Counters stick at all ones.
	function automatic logic [COUNT_W-1:0] sat_add1(input logic [COUNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Raw index of a letter byte with case kept; returns 0 for anything else.
	function automatic bit letter_index(input logic [7:0] b, output logic [IDX_W-1:0] idx);
		idx = '0;
		if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
			idx = IDX_W'(b - CHAR_LOWER_A);
			return 1'b1;
		end
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
			idx = IDX_W'(b - CHAR_UPPER_A + ALPHA_N);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Uppercase lands on lowercase unless case is kept apart.
	function automatic logic [IDX_W-1:0] fold_letter(input logic [IDX_W-1:0] idx);
		if (!case_kept && idx >= IDX_W'(ALPHA_N))
			return idx - IDX_W'(ALPHA_N);
		return idx;
	endfunction

	// Update the predicted counters for one text byte.
	task automatic histogram_count(input logic [7:0] b);
		logic [IDX_W-1:0] raw;
		logic [IDX_W-1:0] slot;
		if (letter_index(b, raw)) begin
			slot = fold_letter(raw);
			occur_cnt[slot] = sat_add1(occur_cnt[slot]);
			letters_seen = sat_add1(letters_seen);
			if (!word_open) begin
				start_cnt[slot] = sat_add1(start_cnt[slot]);
				word_open = 1'b1;
			end
			prev_letter = raw;
		end else if (word_open) begin
			// The ending letter is folded by the mode in force now.
			slot = fold_letter(prev_letter);
			finish_cnt[slot] = sat_add1(finish_cnt[slot]);
			word_open = 1'b0;
		end
	endtask

	// Predicted answer to a read; indexes past the alphabet give zero counts.
	function automatic out_item_t histogram_read(input logic [IDX_W-1:0] q);
		out_item_t r;
		r = '0;
		if (q < NUM_LETTERS) begin
			r.freq_count  = OUT_W'(occur_cnt[q]);
			r.begin_count = OUT_W'(start_cnt[q]);
			r.end_count   = OUT_W'(finish_cnt[q]);
		end
		r.total_letters = OUT_W'(letters_seen);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Track accepted words, predict, and compare results at each rising edge.
	always @(posedge clk) begin
		out_item_t due;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en)
				case_kept = cfg_wr_data;
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				if (in_data.op == OP_READ)
					read_results_due.push_back(word_pinned ? word_want
						: histogram_read(in_data.query_letter));
				else
					histogram_count(in_data.byte_value);
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (read_results_due.size() == 0) begin
					$display("%0t: result with none expected, got %p", $time, out_data);
					errors++;
				end else begin
					due = read_results_due.pop_front();
					check_field("freq_count", due.freq_count, out_data.freq_count);
					check_field("begin_count", due.begin_count, out_data.begin_count);
					check_field("end_count", due.end_count, out_data.end_count);
					check_field("total_letters", due.total_letters, out_data.total_letters);
				end
			end
			// Watchdog on cycles where no word moves on either side.
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// Offer one word, with random idle cycles before it, and wait until it is taken.
	task automatic send_word(input in_item_t w, input bit pin, input out_item_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		in_data     <= w;
		word_pinned <= pin;
		word_want   <= want;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Wait until every read has come back and the command queue has drained.
	task automatic settle();
		in_valid <= 1'b0;
		while (read_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic kept);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= kept;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly text: letters in runs split by spaces, some reads, some raw noise bytes.
	function automatic in_item_t random_text_word();
		in_item_t w;
		int pick;
		w.op           = OP_COUNT;
		w.byte_value   = 8'($urandom);
		w.query_letter = IDX_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			w.op = OP_READ;
			if ($urandom_range(0, 9) != 0)
				w.query_letter = IDX_W'($urandom_range(0, NUM_LETTERS - 1));
		end else if (pick < 70) begin
			w.byte_value = (($urandom_range(0, 3) == 0) ? CHAR_UPPER_A : CHAR_LOWER_A)
				+ 8'($urandom_range(0, ALPHA_N - 1));
		end else if (pick < 88) begin
			w.byte_value = SPACE_CHAR;
		end
		return w;
	endfunction

	function automatic script_row_t make_row(input logic op, input logic [7:0] b,
			input logic [IDX_W-1:0] q, input bit pin, input int f, input int bg,
			input int en, input int tot);
		script_row_t r;
		r.item.op           = op;
		r.item.byte_value   = b;
		r.item.query_letter = q;
		r.pinned            = pin;
		r.want.freq_count    = OUT_W'(f);
		r.want.begin_count   = OUT_W'(bg);
		r.want.end_count     = OUT_W'(en);
		r.want.total_letters = OUT_W'(tot);
		return r;
	endfunction

	initial begin
		script_row_t script[$];
		foreach (occur_cnt[i]) begin
			occur_cnt[i]  = '0;
			start_cnt[i]  = '0;
			finish_cnt[i] = '0;
		end
		letters_seen = '0;
		word_open    = 1'b0;
		prev_letter  = '0;
		case_kept    = 1'b0;

		// Two words "Az" and "Za" split by non-letters, letter-bound neighbors,
		// then reads of folded, never-used and out-of-range indexes.
		script = '{
			make_row(OP_READ,  8'h00, 6'd0,  1'b1, 0, 0, 0, 0),
			make_row(OP_READ,  8'hff, 6'd63, 1'b1, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h41, 6'd63, 1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h7a, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h20, 6'd21, 1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h80, 6'd42, 1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'hff, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h5a, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h61, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h00, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h40, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h5b, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h60, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_COUNT, 8'h7b, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_READ,  8'h00, 6'd0,  1'b1, 2, 1, 1, 4),
			make_row(OP_READ,  8'h00, 6'd25, 1'b1, 2, 1, 1, 4),
			make_row(OP_READ,  8'h00, 6'd26, 1'b1, 0, 0, 0, 4),
			make_row(OP_READ,  8'h00, 6'd51, 1'b1, 0, 0, 0, 4),
			make_row(OP_READ,  8'h00, 6'd52, 1'b1, 0, 0, 0, 4),
			make_row(OP_READ,  8'hff, 6'd63, 1'b1, 0, 0, 0, 4),
			make_row(OP_COUNT, 8'h78, 6'd0,  1'b0, 0, 0, 0, 0),
			make_row(OP_READ,  8'h00, 6'd23, 1'b0, 0, 0, 0, 0),
			// Leaves a word open on an uppercase letter across the first mode change.
			make_row(OP_COUNT, 8'h51, 6'd0,  1'b0, 0, 0, 0, 0)
		};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 16;
		recv_idle_pct = 53;
		foreach (script[i])
			send_word(script[i].item, script[i].pinned, script[i].want);

		// Alternate the case mode while stepping through the idle patterns.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle();
			write_mode(p % 2 == 0);
			case (p / 2)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 53;
				end
				1: begin
					send_idle_pct = 53;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (PHASE_WORDS) send_word(random_text_word(), 1'b0, '0);
		end
		settle();

		if (read_results_due.size() != 0) begin
			$display("%0t: %0d read results never arrived", $time, read_results_due.size());
			errors++;
		end
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
